// File: rtl/pmb_pkg.sv
// Package for the packed Morse beacon player: payload types, segment phases,
// symbol codes, register indexes and reset values. No dependencies.
package pmb_pkg;

	// Input opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// Two-bit symbol codes of a message
	localparam logic [1:0] SYM_PAUSE = 2'd0;
	localparam logic [1:0] SYM_WORD  = 2'd1;
	localparam logic [1:0] SYM_DOT   = 2'd2;
	localparam logic [1:0] SYM_DASH  = 2'd3;

	// Segment lengths in units
	localparam logic [2:0] DOT_UNITS   = 3'd1;
	localparam logic [2:0] DASH_UNITS  = 3'd3;
	localparam logic [2:0] GAP_UNITS   = 3'd1;
	localparam logic [2:0] PAUSE_UNITS = 3'd3;
	localparam logic [2:0] WORD_UNITS  = 3'd7;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_BASE = 3'd1;

	localparam int unsigned UNIT_W = 16;
	localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 16'd200;

	// Reset contents of the four message registers
	localparam logic [63:0] MSG_RESET [4] = '{
		64'd704426, 64'd863164883705, 64'd3017398215615, 64'd56868379228091
	};

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_LIT   = 2'd1,
		PH_GAP   = 2'd2,
		PH_PAUSE = 2'd3
	} phase_t;

	typedef struct packed {
		logic       opcode;
		logic [1:0] message_select;
	} in_item_t;

	typedef struct packed {
		logic [1:0] led_color;
		logic       busy_res;
		logic       done_res;
	} out_item_t;

endpackage

// File: rtl/pmb_chan_if.sv
// Valid/ready channel carrying one payload of type T per transaction.
// Used for the command and result channels; no dependencies.
interface pmb_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/pmb_core.sv
// Playback state and next-state logic of the Morse beacon player.
// Depends on pmb_pkg; message and timing registers come from the top level.
module pmb_core
	import pmb_pkg::*;
#(
	parameter int MESSAGE_COUNT = 4,
	parameter int MESSAGE_BYTES = 6,
	localparam int MSG_W = 8 * MESSAGE_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  in_item_t            item,
	input  logic [UNIT_W-1:0]   unit_ticks,
	input  logic [MSG_W-1:0]    messages [MESSAGE_COUNT],
	output out_item_t           res
);

	localparam int PAIRS  = 4 * MESSAGE_BYTES;
	localparam int POS_W  = $clog2(PAIRS);
	localparam int BYTE_W = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
	localparam logic [2:0] MSG_CNT = 3'(MESSAGE_COUNT);
	localparam logic [POS_W:0] PAIRS_V = (POS_W+1)'(PAIRS);

	logic              playing_q;
	logic [1:0]        chosen_q;
	logic [POS_W-1:0]  pair_q;
	logic [1:0]        color_q;
	phase_t            phase_q;
	logic [2:0]        units_q;
	logic [UNIT_W-1:0] ticks_q;

	logic              playing_n;
	logic [1:0]        chosen_n;
	logic [POS_W-1:0]  pair_n;
	logic [1:0]        color_n;
	phase_t            phase_n;
	logic [2:0]        units_n;
	logic [UNIT_W-1:0] ticks_n;
	logic              done_n;

	logic [2:0]        sel_mod;
	logic              start_idle;
	logic [1:0]        msg_idx;
	logic [MSG_W-1:0]  msg_cur;
	logic [7:0]        byte0;
	logic [UNIT_W-1:0] unit_len;
	logic [POS_W:0]    ld_pos;
	logic [POS_W:0]    ld_pos_byte;
	logic [BYTE_W-1:0] ld_byte_idx;
	logic [7:0]        ld_byte;
	logic [1:0]        ld_sym;
	logic              ld_ok;
	phase_t            ld_phase;
	logic [2:0]        ld_units;

	// Wrap the select into the message count
	always_comb begin
		sel_mod = {1'b0, item.message_select};
		for (int i = 0; i < 4; i++) begin
			if (sel_mod >= MSG_CNT) begin
				sel_mod = sel_mod - MSG_CNT;
			end
		end
	end

	assign start_idle = accept && (item.opcode == OP_START) && !playing_q;
	assign msg_idx    = start_idle ? sel_mod[1:0] : chosen_q;
	assign msg_cur    = messages[msg_idx];
	assign byte0      = msg_cur[7:0];
	assign unit_len   = (unit_ticks == '0) ? UNIT_W'(1) : unit_ticks;

	// Symbol load: fetch the pair at ld_pos and decode its segment
	assign ld_pos      = start_idle ? (POS_W+1)'(1) : ({1'b0, pair_q} + (POS_W+1)'(1));
	assign ld_pos_byte = ld_pos >> 2;
	assign ld_byte_idx = BYTE_W'(ld_pos_byte);
	assign ld_byte     = msg_cur[ld_byte_idx*8 +: 8];
	assign ld_sym      = ld_byte[ld_pos[1:0]*2 +: 2];
	assign ld_ok       = (ld_pos < PAIRS_V) && !((ld_pos[1:0] == 2'd0) && (ld_byte == 8'd0));

	always_comb begin
		unique case (ld_sym)
			SYM_DOT: begin
				ld_phase = PH_LIT;
				ld_units = DOT_UNITS;
			end
			SYM_DASH: begin
				ld_phase = PH_LIT;
				ld_units = DASH_UNITS;
			end
			SYM_WORD: begin
				ld_phase = PH_PAUSE;
				ld_units = WORD_UNITS;
			end
			default: begin
				ld_phase = PH_PAUSE;
				ld_units = PAUSE_UNITS;
			end
		endcase
	end

	// Next state for one accepted transaction
	always_comb begin
		playing_n = playing_q;
		chosen_n  = chosen_q;
		pair_n    = pair_q;
		color_n   = color_q;
		phase_n   = phase_q;
		units_n   = units_q;
		ticks_n   = ticks_q;
		done_n    = 1'b0;
		if (start_idle) begin
			chosen_n = sel_mod[1:0];
			if (byte0 == 8'd0 || !ld_ok) begin
				playing_n = 1'b0;
				pair_n    = '0;
				color_n   = 2'd0;
				phase_n   = PH_IDLE;
				units_n   = 3'd0;
				ticks_n   = '0;
				done_n    = 1'b1;
			end else begin
				playing_n = 1'b1;
				color_n   = byte0[1:0];
				pair_n    = POS_W'(ld_pos);
				phase_n   = ld_phase;
				units_n   = ld_units;
				ticks_n   = unit_len;
			end
		end else if (accept && (item.opcode == OP_TICK) && playing_q) begin
			if (ticks_q > UNIT_W'(1)) begin
				ticks_n = ticks_q - UNIT_W'(1);
			end else if (units_q > 3'd1) begin
				units_n = units_q - 3'd1;
				ticks_n = unit_len;
			end else if (phase_q == PH_LIT) begin
				phase_n = PH_GAP;
				units_n = GAP_UNITS;
				ticks_n = unit_len;
			end else if (ld_ok) begin
				pair_n  = POS_W'(ld_pos);
				phase_n = ld_phase;
				units_n = ld_units;
				ticks_n = unit_len;
			end else begin
				playing_n = 1'b0;
				pair_n    = '0;
				color_n   = 2'd0;
				phase_n   = PH_IDLE;
				units_n   = 3'd0;
				ticks_n   = '0;
				done_n    = 1'b1;
			end
		end
	end

	// Result as seen after the update
	always_comb begin
		res.led_color = (playing_n && phase_n == PH_LIT) ? color_n : 2'd0;
		res.busy_res  = playing_n;
		res.done_res  = done_n;
	end

	// Hold playback state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
			chosen_q  <= 2'd0;
			pair_q    <= '0;
			color_q   <= 2'd0;
			phase_q   <= PH_IDLE;
			units_q   <= 3'd0;
			ticks_q   <= '0;
		end else begin
			playing_q <= playing_n;
			chosen_q  <= chosen_n;
			pair_q    <= pair_n;
			color_q   <= color_n;
			phase_q   <= phase_n;
			units_q   <= units_n;
			ticks_q   <= ticks_n;
		end
	end

endmodule

// File: rtl/packed_morse_beacon_player.sv
// Packed Morse beacon player, top level: configuration registers, playback
// core and result buffering. Depends on pmb_pkg, pmb_chan_if and pmb_core.
//
// Usage: each command transaction is a tick (opcode 0) or a start (opcode 1,
// with message_select). A start while idle picks a message, whose first bit pair
// sets the LED color; later pairs play as dots, dashes and pauses, timed in
// units of unit_ticks ticks. A start while playing is ignored.
// Every command yields exactly one result transaction: led_color, busy_res and
// done_res as they stand after that command.
// Each result is registered in the result register, or in the skid entry.
// Throughput: one command per cycle while cmd.ready is high; the small playback
// counters are updated combinationally between the state and result registers.
// Stall: the result register is backed by one skid entry, so one more command
// is taken while a result waits; cmd.ready drops only when the skid entry is
// full and returns once a result is taken and the skid entry has emptied.
// Reset: playback goes idle, buffered results are dropped, unit_ticks and the
// messages return to their defaults. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while the block is idle; it is not enforced.
module packed_morse_beacon_player
	import pmb_pkg::*;
#(
	parameter int MESSAGE_COUNT = 4,
	parameter int MESSAGE_BYTES = 6,
	localparam int MSG_W = 8 * MESSAGE_BYTES,
	localparam int CFG_W = (MSG_W > UNIT_W) ? MSG_W : UNIT_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	pmb_chan_if.sink             cmd,
	pmb_chan_if.source           result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [UNIT_W-1:0] unit_ticks_q;
	logic [MSG_W-1:0]  messages_q [MESSAGE_COUNT];
	logic              accept;
	in_item_t          cmd_item;
	out_item_t         core_res;
	logic              out_valid_q;
	out_item_t         out_q;
	logic              skid_valid_q;
	out_item_t         skid_q;
	logic              out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= UNIT_TICKS_RESET;
			for (int m = 0; m < MESSAGE_COUNT; m++) begin
				messages_q[m] <= MSG_RESET[m][MSG_W-1:0];
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_UNIT_TICKS) begin
				unit_ticks_q <= cfg_data[UNIT_W-1:0];
			end
			for (int m = 0; m < MESSAGE_COUNT; m++) begin
				if (cfg_index == REG_MESSAGE_BASE + CFG_IDX_W'(m)) begin
					messages_q[m] <= cfg_data[MSG_W-1:0];
				end
			end
		end
	end

	assign cmd_item  = cmd.data;
	assign cmd.ready = !skid_valid_q;
	assign accept    = cmd.valid && cmd.ready;

	pmb_core #(
		.MESSAGE_COUNT(MESSAGE_COUNT),
		.MESSAGE_BYTES(MESSAGE_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (cmd_item),
		.unit_ticks (unit_ticks_q),
		.messages   (messages_q),
		.res        (core_res)
	);

	assign out_free = result.ready || !out_valid_q;

	// Advance result register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Hold result payloads
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : core_res;
		end else if (accept) begin
			skid_q <= core_res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// Checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry full while result register empty");

	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !out_valid_q) |=> out_valid_q)
		else $error("accepted command produced no result");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.done_res) |-> !result.data.busy_res)
		else $error("done reported while still busy");

	a_lit_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.led_color != 2'd0) |-> result.data.busy_res)
		else $error("LED lit while idle");

endmodule

// File: tb/sv/packed_morse_beacon_player_tb.sv
// Self-checking testbench for packed_morse_beacon_player: bursty command driver,
// stalling result sink, and a cycle-free beacon predictor checked per transaction.
// Depends on pmb_pkg, pmb_chan_if and the packed_morse_beacon_player RTL.
module packed_morse_beacon_player_tb;
	import pmb_pkg::*;

	localparam int MESSAGE_COUNT  = 4;
	localparam int MESSAGE_BYTES  = 6;
	localparam int MSG_W          = 8 * MESSAGE_BYTES;
	localparam int RANDOM_ITEMS   = 200;
	localparam int TIMEOUT_CYCLES = 3_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MSG_W-1:0]     cfg_data;

	pmb_chan_if #(.T(in_item_t))  cmd_if ();
	pmb_chan_if #(.T(out_item_t)) res_if ();

	packed_morse_beacon_player dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_if),
		.result    (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Commands waiting for the driver and results waiting for the block
	in_item_t  pending_cmd_q [$];
	out_item_t beacon_out_q [$];
	int unsigned mismatch_count = 0;
	bit cmd_took = 1'b0;

	// Shadow configuration
	logic [UNIT_W-1:0] unit_cfg;
	logic [MSG_W-1:0]  message_cfg [MESSAGE_COUNT];

	// Shadow playback state
	bit         bcn_playing;
	logic [1:0] bcn_msg;
	logic [4:0] bcn_pos;
	logic [1:0] bcn_color;
	phase_t     bcn_phase;
	logic [2:0] bcn_units;
	logic [15:0] bcn_ticks;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [15:0] unit_len();
		return (unit_cfg == '0) ? 16'd1 : unit_cfg;
	endfunction

	function automatic logic [7:0] msg_byte(input int unsigned idx);
		logic [MSG_W-1:0] m;
		m = message_cfg[bcn_msg];
		return (idx < MESSAGE_BYTES) ? m[8*idx +: 8] : 8'h00;
	endfunction

	function automatic void halt_play();
		bcn_playing = 1'b0;
		bcn_pos     = '0;
		bcn_color   = '0;
		bcn_phase   = PH_IDLE;
		bcn_units   = '0;
		bcn_ticks   = '0;
	endfunction

	// Load the symbol at a pair index; return 0 when the message has ended
	function automatic bit load_symbol(input int unsigned pos);
		logic [7:0] b;
		logic [1:0] sym;
		if (pos >= MESSAGE_BYTES * 4)
			return 1'b0;
		b = msg_byte(pos / 4);
		if ((pos % 4) == 0 && b == 8'h00)
			return 1'b0;
		sym = 2'(b >> ((pos % 4) * 2));
		bcn_pos = 5'(pos);
		case (sym)
			SYM_DOT: begin
				bcn_phase = PH_LIT;
				bcn_units = DOT_UNITS;
			end
			SYM_DASH: begin
				bcn_phase = PH_LIT;
				bcn_units = DASH_UNITS;
			end
			SYM_WORD: begin
				bcn_phase = PH_PAUSE;
				bcn_units = WORD_UNITS;
			end
			default: begin
				bcn_phase = PH_PAUSE;
				bcn_units = PAUSE_UNITS;
			end
		endcase
		bcn_ticks = unit_len();
		return 1'b1;
	endfunction

	// Advance the shadow beacon by one command and return what the LED shows
	function automatic out_item_t step_beacon(input in_item_t it);
		out_item_t  r;
		logic [7:0] first;
		bit         done;
		done = 1'b0;
		if (it.opcode == OP_START) begin
			if (!bcn_playing) begin
				bcn_msg = 2'(it.message_select % MESSAGE_COUNT);
				first = msg_byte(0);
				if (first == 8'h00) begin
					halt_play();
					done = 1'b1;
				end else begin
					bcn_playing = 1'b1;
					bcn_color = first[1:0];
					if (!load_symbol(1)) begin
						halt_play();
						done = 1'b1;
					end
				end
			end
		end else if (bcn_playing) begin
			if (bcn_ticks > 16'd1) begin
				bcn_ticks = bcn_ticks - 16'd1;
			end else if (bcn_units > 3'd1) begin
				bcn_units = bcn_units - 3'd1;
				bcn_ticks = unit_len();
			end else if (bcn_phase == PH_LIT) begin
				bcn_phase = PH_GAP;
				bcn_units = GAP_UNITS;
				bcn_ticks = unit_len();
			end else if (!load_symbol(int'(bcn_pos) + 1)) begin
				halt_play();
				done = 1'b1;
			end
		end
		r.led_color = (bcn_playing && bcn_phase == PH_LIT) ? bcn_color : 2'd0;
		r.busy_res  = bcn_playing;
		r.done_res  = done;
		return r;
	endfunction

	// Drive commands in bursts; hold an offered transaction until it is taken
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	always @(negedge clk) begin
		if (cmd_if.valid && !cmd_took) begin
			// hold
		end else if (gap_left != 0) begin
			gap_left--;
			cmd_if.valid <= 1'b0;
		end else begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 48);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			end else begin
				burst_left--;
			end
			if (pending_cmd_q.size() != 0) begin
				cmd_if.valid <= 1'b1;
				cmd_if.data  <= pending_cmd_q[0];
			end else begin
				cmd_if.valid <= 1'b0;
			end
		end
	end

	// Stall the result channel: always ready, random, or in short stall runs
	int unsigned rdy_mode = 0;
	int unsigned rdy_span = 0;
	int unsigned stall_left = 0;
	always @(negedge clk) begin
		if (rdy_span == 0) begin
			rdy_mode = $urandom_range(0, 2);
			rdy_span = $urandom_range(20, 200);
		end else begin
			rdy_span--;
		end
		case (rdy_mode)
			0: res_if.ready <= 1'b1;
			1: res_if.ready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (stall_left != 0) begin
					stall_left--;
					res_if.ready <= 1'b0;
				end else begin
					res_if.ready <= 1'b1;
					if ($urandom_range(0, 5) == 0)
						stall_left = $urandom_range(1, 8);
				end
			end
		endcase
	end

	// Check each result transaction, then predict for each command transaction
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (res_if.valid && res_if.ready) begin
			got = res_if.data;
			if (beacon_out_q.size() == 0) begin
				$display("%0t: result with nothing expected: led %0d busy %0d done %0d",
					$time, got.led_color, got.busy_res, got.done_res);
				mismatch_count++;
			end else begin
				want = beacon_out_q.pop_front();
				if (got.led_color !== want.led_color) begin
					$display("%0t: led_color expected %0d actual %0d",
						$time, want.led_color, got.led_color);
					mismatch_count++;
				end
				if (got.busy_res !== want.busy_res) begin
					$display("%0t: busy_res expected %0d actual %0d",
						$time, want.busy_res, got.busy_res);
					mismatch_count++;
				end
				if (got.done_res !== want.done_res) begin
					$display("%0t: done_res expected %0d actual %0d",
						$time, want.done_res, got.done_res);
					mismatch_count++;
				end
			end
		end
		cmd_took = cmd_if.valid && cmd_if.ready && arst_n;
		if (cmd_took) begin
			beacon_out_q.push_back(step_beacon(cmd_if.data));
			void'(pending_cmd_q.pop_front());
		end
	end

	task automatic push_cmd(input logic op, input logic [1:0] sel);
		in_item_t it;
		it.opcode = op;
		it.message_select = sel;
		pending_cmd_q.push_back(it);
	endtask

	// Wait until every command is taken and every result has come back
	task automatic wait_quiet();
		while (pending_cmd_q.size() != 0 || beacon_out_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MSG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_UNIT_TICKS)
			unit_cfg = val[UNIT_W-1:0];
		else
			message_cfg[2'(idx - REG_MESSAGE_BASE)] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Tick until the shadow beacon has finished its message
	task automatic play_out();
		wait_quiet();
		while (bcn_playing) begin
			repeat (32) push_cmd(OP_TICK, 2'($urandom_range(0, 3)));
			wait_quiet();
		end
	endtask

	// Build a message: mostly nonzero bytes ended by a zero byte, some empty or full
	function automatic logic [MSG_W-1:0] random_message();
		logic [MSG_W-1:0] m;
		int unsigned kind;
		int unsigned len;
		for (int i = 0; i < MESSAGE_BYTES; i++)
			m[8*i +: 8] = 8'($urandom_range(1, 255));
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			m[7:0] = 8'h00;
		end else if (kind > 2) begin
			len = $urandom_range(1, MESSAGE_BYTES - 1);
			m[8*len +: 8] = 8'h00;
			for (int i = len + 1; i < MESSAGE_BYTES; i++)
				m[8*i +: 8] = 8'($urandom);
		end
		return m;
	endfunction

	function automatic logic [UNIT_W-1:0] random_unit();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return '0;
		if (r == 1)
			return UNIT_W'($urandom_range(4, 12));
		return UNIT_W'($urandom_range(1, 3));
	endfunction

	initial begin
		int unsigned random_count;
		int unsigned batch;
		int unsigned k;
		cmd_if.valid = 1'b0;
		cmd_if.data  = '0;
		res_if.ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		unit_cfg  = UNIT_TICKS_RESET;
		for (int i = 0; i < MESSAGE_COUNT; i++)
			message_cfg[i] = MSG_RESET[i][MSG_W-1:0];
		halt_play();
		bcn_msg = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: start, a few ticks, a start while busy, then shorten the unit
		push_cmd(OP_START, 2'd0);
		repeat (3) push_cmd(OP_TICK, 2'd1);
		push_cmd(OP_START, 2'd3);
		wait_quiet();
		write_reg(REG_UNIT_TICKS, 48'd1);
		play_out();
		for (int i = 1; i < MESSAGE_COUNT; i++) begin
			push_cmd(OP_START, 2'(i));
			play_out();
		end

		// Empty message, color pair zero, all-ones message, one-byte message, zero unit
		write_reg(CFG_IDX_W'(REG_MESSAGE_BASE + 0), 48'h0000_0000_0000);
		write_reg(CFG_IDX_W'(REG_MESSAGE_BASE + 1), 48'hE4E4_E4E4_E41C);
		write_reg(CFG_IDX_W'(REG_MESSAGE_BASE + 2), 48'hFFFF_FFFF_FFFF);
		write_reg(CFG_IDX_W'(REG_MESSAGE_BASE + 3), 48'h0000_0000_005B);
		write_reg(REG_UNIT_TICKS, 48'd0);
		push_cmd(OP_START, 2'd0);
		push_cmd(OP_TICK, 2'd2);
		push_cmd(OP_START, 2'd1);
		play_out();
		push_cmd(OP_START, 2'd3);
		push_cmd(OP_START, 2'd2);
		play_out();

		// Wide unit write keeps only the low bits; shorten the unit mid-play and
		// run the all-ones message to its last pair
		write_reg(REG_UNIT_TICKS, 48'hFFFF_0000_0005);
		push_cmd(OP_START, 2'd2);
		repeat (4) push_cmd(OP_TICK, 2'd0);
		wait_quiet();
		write_reg(REG_UNIT_TICKS, 48'd1);
		play_out();

		// Random batches with reconfiguration between them, live while playing
		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_UNIT_TICKS, MSG_W'(random_unit()));
				for (int i = 0; i < MESSAGE_COUNT; i++)
					write_reg(CFG_IDX_W'(REG_MESSAGE_BASE + i), random_message());
			end else begin
				repeat ($urandom_range(1, 2)) begin
					k = $urandom_range(0, MESSAGE_COUNT);
					if (k == 0)
						write_reg(REG_UNIT_TICKS, MSG_W'(random_unit()));
					else
						write_reg(CFG_IDX_W'(REG_MESSAGE_BASE + k - 1), random_message());
				end
			end
			batch = $urandom_range(30, 120);
			repeat (batch)
				push_cmd(($urandom_range(0, 7) == 0) ? OP_START : OP_TICK,
					2'($urandom_range(0, 3)));
			random_count += batch;
			wait_quiet();
		end
		play_out();
		repeat (4) @(posedge clk);

		if (mismatch_count == 0 && beacon_out_q.size() == 0) begin
			$display("packed_morse_beacon_player_tb OK");
		end else begin
			$display("packed_morse_beacon_player_tb NOT OK");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#(TIMEOUT_CYCLES * 12);
		$display("packed_morse_beacon_player_tb NOT OK");
		$finish;
	end

endmodule

// File: files.f
rtl/pmb_pkg.sv
rtl/pmb_chan_if.sv
rtl/pmb_core.sv
rtl/packed_morse_beacon_player.sv
tb/sv/packed_morse_beacon_player_tb.sv
